>>> src/dlm_pkg.sv
// ----------------------------------------------------------------------------
// dlm_pkg
// Shared constants, payload types and memory port structures for the decimal
// long multiplier.
// ----------------------------------------------------------------------------
package dlm_pkg;

  localparam int INPUT_DIGITS   = 10;
  localparam int PRODUCT_DIGITS = 20;
  localparam int OPERAND_W      = 31;
  localparam int DIGIT_W        = 4;

  localparam int LEN_W   = $clog2(INPUT_DIGITS + 1);
  localparam int POS_W   = LEN_W + 1;
  localparam int DIG_DEPTH = 2 * INPUT_DIGITS;
  localparam int DIG_AW  = $clog2(DIG_DEPTH);
  localparam int PROD_AW = $clog2(PRODUCT_DIGITS);

  localparam int          RECIP_W     = 32;
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic [OPERAND_W-1:0] operand_a;
    logic [OPERAND_W-1:0] operand_b;
  } item_t;

  typedef struct packed {
    digit_t digit;
    logic   last;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic                 step;
    logic [OPERAND_W-1:0] value;
  } split_ctl_t;

  typedef struct packed {
    digit_t digit;
    logic   zero;
  } split_stat_t;

  typedef struct packed {
    logic              en;
    logic [DIG_AW-1:0] addr;
    digit_t            data;
  } dig_wr_t;

  typedef struct packed {
    logic               en;
    logic [PROD_AW-1:0] addr;
    digit_t             data;
  } prod_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT_A,
    ST_SPLIT_B,
    ST_MUL,
    ST_MUL_DRAIN,
    ST_STRIP_RD,
    ST_STRIP_CHK,
    ST_EMIT,
    ST_ZERO,
    ST_EMIT_END
  } state_t;

endpackage

>>> src/dlm_split.sv
// ----------------------------------------------------------------------------
// dlm_split
// Decimal digit extractor: holds a binary value and peels off its least
// significant decimal digit once per step by reciprocal multiplication.
// ----------------------------------------------------------------------------
module dlm_split (
  input  logic                clk,
  input  dlm_pkg::split_ctl_t ctl,
  output dlm_pkg::split_stat_t stat
);
  import dlm_pkg::*;

  localparam int PROD_W = OPERAND_W + RECIP_W;

  logic [OPERAND_W-1:0] value;
  logic [PROD_W-1:0]    prod;
  logic [OPERAND_W-1:0] quot;
  logic [OPERAND_W-1:0] rem;

  assign prod = PROD_W'(value) * PROD_W'(RECIP_TEN);
  assign quot = OPERAND_W'(prod >> RECIP_SHIFT);
  assign rem  = value - ((quot << 3) + (quot << 1));

  assign stat.digit = DIGIT_W'(rem);
  assign stat.zero  = (value == '0);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      value <= ctl.value;
    end else if (ctl.step) begin
      value <= quot;
    end
  end

endmodule

>>> src/dlm_digit_ram.sv
// ----------------------------------------------------------------------------
// dlm_digit_ram
// Operand digit store: the digits of the first operand at the low half and
// of the second operand at the high half. One write port, two registered
// read ports.
// ----------------------------------------------------------------------------
module dlm_digit_ram (
  input  logic                        clk,
  input  dlm_pkg::dig_wr_t            wr,
  input  logic [dlm_pkg::DIG_AW-1:0]  raddr_a,
  input  logic [dlm_pkg::DIG_AW-1:0]  raddr_b,
  output dlm_pkg::digit_t             rdata_a,
  output dlm_pkg::digit_t             rdata_b
);
  import dlm_pkg::*;

  digit_t mem [DIG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> src/dlm_prod_ram.sv
// ----------------------------------------------------------------------------
// dlm_prod_ram
// Product digit store, least significant digit at address zero. One write
// port and one registered read port; a read at the written address returns
// the old contents.
// ----------------------------------------------------------------------------
module dlm_prod_ram (
  input  logic                        clk,
  input  dlm_pkg::prod_wr_t           wr,
  input  logic [dlm_pkg::PROD_AW-1:0] raddr,
  output dlm_pkg::digit_t             rdata
);
  import dlm_pkg::*;

  digit_t mem [PRODUCT_DIGITS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/dlm_ctrl.sv
// ----------------------------------------------------------------------------
// dlm_ctrl
// Sequencer and digit multiply-accumulate datapath. Splits both operands into
// the digit store, runs the schoolbook rows through a read-modify-write
// pipeline on the product store, strips the leading zero and streams the
// product digits out.
// ----------------------------------------------------------------------------
module dlm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  dlm_pkg::item_t              operands,
  output logic                        busy,
  output logic                        valid,
  output dlm_pkg::result_t            result,
  output dlm_pkg::split_ctl_t         split_ctl,
  input  dlm_pkg::split_stat_t        split_stat,
  output dlm_pkg::dig_wr_t            dig_wr,
  output logic [dlm_pkg::DIG_AW-1:0]  dig_raddr_a,
  output logic [dlm_pkg::DIG_AW-1:0]  dig_raddr_b,
  input  dlm_pkg::digit_t             dig_rdata_a,
  input  dlm_pkg::digit_t             dig_rdata_b,
  output dlm_pkg::prod_wr_t           prod_wr,
  output logic [dlm_pkg::PROD_AW-1:0] prod_raddr,
  input  dlm_pkg::digit_t             prod_rdata
);
  import dlm_pkg::*;

  localparam int SUM_W = 7;

  function automatic digit_t div10(input logic [SUM_W-1:0] v);
    digit_t q;
    q = '0;
    for (int t = 1; t < 10; t++) begin
      if (v >= SUM_W'(10 * t)) begin
        q = DIGIT_W'(t);
      end
    end
    return q;
  endfunction

  state_t state;
  state_t state_next;

  logic [OPERAND_W-1:0] opb;
  logic [LEN_W-1:0]     la;
  logic [LEN_W-1:0]     lb;
  logic [LEN_W-1:0]     row;
  logic [LEN_W-1:0]     col;
  logic [PROD_AW-1:0]   idx;

  logic                 s1_valid;
  logic                 s1_extra;
  logic                 s1_first;
  logic                 s1_oor;
  logic                 s1_row_start;
  logic                 s1_fwd;
  digit_t               s1_fwd_data;
  logic [PROD_AW-1:0]   s1_addr;
  digit_t               carry;

  logic                 e_valid;
  logic                 e_last;
  logic                 e_zero;

  logic                 is_zero;
  logic                 split_done;
  logic [LEN_W-1:0]     split_cnt;
  logic [POS_W-1:0]     kpos;
  logic                 kpos_oor;
  logic                 col_end;
  logic                 row_end;
  logic [POS_W-1:0]     total;
  logic [PROD_AW-1:0]   top_idx;

  digit_t               aj;
  digit_t               pold;
  digit_t               cin;
  logic [7:0]           pp;
  logic [SUM_W-1:0]     sum;
  digit_t               sum_q;
  logic [SUM_W-1:0]     sum_r;

  assign is_zero    = (operands.operand_a == '0) || (operands.operand_b == '0);
  assign split_cnt  = (state == ST_SPLIT_A) ? la : lb;
  assign split_done = split_stat.zero || (split_cnt == LEN_W'(INPUT_DIGITS));
  assign kpos       = POS_W'(row) + POS_W'(col);
  assign kpos_oor   = 32'(kpos) >= 32'(PRODUCT_DIGITS);
  assign col_end    = (col == la);
  assign row_end    = (LEN_W'(row + LEN_W'(1)) == lb);
  assign total      = POS_W'(la) + POS_W'(lb);
  assign top_idx    = (32'(total) > 32'(PRODUCT_DIGITS)) ? PROD_AW'(PRODUCT_DIGITS - 1)
                                                         : PROD_AW'(total - POS_W'(1));

  // Multiply-accumulate stage on the data returned by the stores.
  assign aj    = s1_extra ? '0 : dig_rdata_a;
  assign pold  = (s1_first || s1_extra || s1_oor) ? '0 :
                 (s1_fwd ? s1_fwd_data : prod_rdata);
  assign cin   = s1_row_start ? '0 : carry;
  assign pp    = 8'(aj) * 8'(dig_rdata_b);
  assign sum   = SUM_W'(pold) + SUM_W'(pp) + SUM_W'(cin);
  assign sum_q = div10(sum);
  assign sum_r = sum - ((SUM_W'(sum_q) << 3) + (SUM_W'(sum_q) << 1));

  assign prod_wr.en   = s1_valid && !s1_oor;
  assign prod_wr.addr = s1_addr;
  assign prod_wr.data = DIGIT_W'(sum_r);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = is_zero ? ST_ZERO : ST_SPLIT_A;
        end
      end
      ST_SPLIT_A: begin
        if (split_done) begin
          state_next = ST_SPLIT_B;
        end
      end
      ST_SPLIT_B: begin
        if (split_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (col_end && row_end) begin
          state_next = ST_MUL_DRAIN;
        end
      end
      ST_MUL_DRAIN: state_next = ST_STRIP_RD;
      ST_STRIP_RD:  state_next = ST_STRIP_CHK;
      ST_STRIP_CHK: begin
        if ((prod_rdata == '0) && (idx != '0)) begin
          state_next = ST_STRIP_RD;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (idx == '0) begin
          state_next = ST_EMIT_END;
        end
      end
      ST_ZERO:     state_next = ST_EMIT_END;
      ST_EMIT_END: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    split_ctl.load  = ((state == ST_IDLE) && start) || ((state == ST_SPLIT_A) && split_done);
    split_ctl.step  = ((state == ST_SPLIT_A) || (state == ST_SPLIT_B)) && !split_done;
    split_ctl.value = (state == ST_IDLE) ? operands.operand_a : opb;

    dig_wr.en   = split_ctl.step;
    dig_wr.addr = (state == ST_SPLIT_A) ? DIG_AW'(la)
                                        : DIG_AW'(INPUT_DIGITS) + DIG_AW'(lb);
    dig_wr.data = split_stat.digit;

    dig_raddr_a = DIG_AW'(col);
    dig_raddr_b = DIG_AW'(INPUT_DIGITS) + DIG_AW'(row);
    prod_raddr  = (state == ST_MUL) ? PROD_AW'(kpos) : idx;

    busy          = (state != ST_IDLE);
    valid         = e_valid;
    result.digit  = e_zero ? '0 : prod_rdata;
    result.last   = e_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
      e_valid  <= 1'b0;
      e_last   <= 1'b0;
      e_zero   <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == ST_MUL);
      e_valid  <= (state == ST_EMIT) || (state == ST_ZERO);
      e_last   <= (state == ST_ZERO) || (idx == '0);
      e_zero   <= (state == ST_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        opb <= operands.operand_b;
        la  <= '0;
      end
      ST_SPLIT_A: begin
        if (split_done) begin
          lb <= '0;
        end else begin
          la <= LEN_W'(la + LEN_W'(1));
        end
      end
      ST_SPLIT_B: begin
        if (split_done) begin
          row <= '0;
          col <= '0;
        end else begin
          lb <= LEN_W'(lb + LEN_W'(1));
        end
      end
      ST_MUL: begin
        if (col_end) begin
          col <= '0;
          row <= LEN_W'(row + LEN_W'(1));
        end else begin
          col <= LEN_W'(col + LEN_W'(1));
        end
      end
      ST_MUL_DRAIN: idx <= top_idx;
      ST_STRIP_CHK: begin
        if ((prod_rdata == '0) && (idx != '0)) begin
          idx <= PROD_AW'(idx - PROD_AW'(1));
        end
      end
      ST_EMIT: begin
        if (idx != '0) begin
          idx <= PROD_AW'(idx - PROD_AW'(1));
        end
      end
      default: begin
      end
    endcase

    // Operation issued to the product store this cycle. A write to the
    // same entry in this cycle is captured, since the read returns old data.
    s1_extra     <= col_end;
    s1_first     <= (row == '0);
    s1_oor       <= kpos_oor;
    s1_row_start <= (col == '0);
    s1_addr      <= PROD_AW'(kpos);
    s1_fwd       <= prod_wr.en && !kpos_oor && (prod_wr.addr == PROD_AW'(kpos));
    s1_fwd_data  <= prod_wr.data;

    if (s1_valid) begin
      carry <= sum_q;
    end
  end

endmodule

>>> src/decimal_long_multiplier.sv
// ----------------------------------------------------------------------------
// decimal_long_multiplier
// Multiplies two 31-bit binary integers by schoolbook decimal digit products
// and streams the product's decimal digits, most significant first.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low;
// operands carries both factors. busy stays high until the last result of
// that transaction has been shown.
// Results appear on result, one digit per cycle, each marked by valid for
// exactly one cycle and taken at the edge that ends it. The digits of one
// product come in consecutive cycles and result.last marks the least
// significant one. Leading zeros are stripped; a zero factor gives the single
// digit 0. The receiver cannot stall the stream.
// The product store has a single read-modify-write path, one digit product
// per cycle.
// One transaction is worked on at a time.
// Reset (synchronous, active high) returns the block to idle and drops any
// transaction in flight; the digit stores need no clearing.
// ----------------------------------------------------------------------------
module decimal_long_multiplier (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  dlm_pkg::item_t   operands,
  output logic             busy,
  output logic             valid,
  output dlm_pkg::result_t result
);
  import dlm_pkg::*;

  split_ctl_t          split_ctl;
  split_stat_t         split_stat;
  dig_wr_t             dig_wr;
  logic [DIG_AW-1:0]   dig_raddr_a;
  logic [DIG_AW-1:0]   dig_raddr_b;
  digit_t              dig_rdata_a;
  digit_t              dig_rdata_b;
  prod_wr_t            prod_wr;
  logic [PROD_AW-1:0]  prod_raddr;
  digit_t              prod_rdata;

  dlm_split u_split (
    .clk  (clk),
    .ctl  (split_ctl),
    .stat (split_stat)
  );

  dlm_digit_ram u_digit_ram (
    .clk     (clk),
    .wr      (dig_wr),
    .raddr_a (dig_raddr_a),
    .raddr_b (dig_raddr_b),
    .rdata_a (dig_rdata_a),
    .rdata_b (dig_rdata_b)
  );

  dlm_prod_ram u_prod_ram (
    .clk   (clk),
    .wr    (prod_wr),
    .raddr (prod_raddr),
    .rdata (prod_rdata)
  );

  dlm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operands    (operands),
    .busy        (busy),
    .valid       (valid),
    .result      (result),
    .split_ctl   (split_ctl),
    .split_stat  (split_stat),
    .dig_wr      (dig_wr),
    .dig_raddr_a (dig_raddr_a),
    .dig_raddr_b (dig_raddr_b),
    .dig_rdata_a (dig_rdata_a),
    .dig_rdata_b (dig_rdata_b),
    .prod_wr     (prod_wr),
    .prod_raddr  (prod_raddr),
    .prod_rdata  (prod_rdata)
  );

endmodule

>>> src/dlm_checker.sv
// ----------------------------------------------------------------------------
// dlm_checker
// Port-level checks on the digit stream of the decimal long multiplier.
// ----------------------------------------------------------------------------
module dlm_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             valid,
  input dlm_pkg::result_t result
);
  import dlm_pkg::*;

  // The digits of one product arrive without gaps.
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    valid && !result.last |=> valid)
    else $error("digit stream broken before the last digit");

  // Nothing follows the last digit of a product in the next cycle.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    valid && result.last |=> !valid)
    else $error("result shown right after the last digit");

  // Results belong to a transaction in progress.
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy)
    else $error("result shown while idle");

  // Every digit shown is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.digit <= DIGIT_W'(9)))
    else $error("digit out of decimal range");

  // An accepted transaction keeps the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted transaction");

endmodule

bind decimal_long_multiplier dlm_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .valid  (valid),
  .result (result)
);
